### rtl/core/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Shared constants, codes, types and the lowest-clear-bit search.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int BITMAP_WORDS = 128;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int ADDR_W       = $clog2(BITMAP_WORDS);
    localparam int CNT_W        = 8;
    localparam int FRAME_W      = 12;
    localparam int MAX_WORDS    = 128;

    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_ALREADY_MAPPED  = 3'd1,
        ST_FULL            = 3'd2,
        ST_OUT_OF_RANGE    = 3'd3,
        ST_NOTHING_TO_FREE = 3'd4
    } t_status;

    typedef struct packed {
        logic               done;
        logic [FRAME_W-1:0] frame;
        t_status            status;
        logic               present;
        logic               rw;
        logic               user;
    } t_result;

    // Index of the lowest clear bit, searched byte by byte.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [3:0] has;
        logic [1:0] sel;
        logic [7:0] bsel;
        logic [2:0] pos;
        for (int i = 0; i < 4; i++) begin
            has[i] = ~&w[i*8 +: 8];
        end
        sel = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (has[i]) begin
                sel = 2'(i);
            end
        end
        bsel = w[sel*8 +: 8];
        pos  = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (!bsel[j]) begin
                pos = 3'(j);
            end
        end
        return {sel, pos};
    endfunction

endpackage

### rtl/core/fba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator sequencer
// Scans the bitmap memory one word per cycle and writes back the update.
// ----------------------------------------------------------------------------
module fba_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_cmd,
    input  logic [fba_pkg::FRAME_W-1:0]          i_frame_in,
    input  logic                                 i_kernel_page,
    input  logic                                 i_writable,
    input  logic [fba_pkg::CNT_W-1:0]            i_nwords,
    output logic                                 o_ram_we,
    output logic [fba_pkg::ADDR_W-1:0]           o_ram_waddr,
    output logic [fba_pkg::WORD_BITS-1:0]        o_ram_wdata,
    output logic                                 o_ram_re,
    output logic [fba_pkg::ADDR_W-1:0]           o_ram_raddr,
    input  logic [fba_pkg::WORD_BITS-1:0]        i_ram_rdata,
    output logic                                 o_busy,
    output fba_pkg::t_result                     o_res
);
    import fba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FREE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic                r_kernel, n_kernel;
    logic                r_wr, n_wr;
    logic [BITMAP_WORDS-1:0] r_valid;
    logic                r_rd_valid;
    t_result             r_res, n_res;

    logic                     accept;
    logic [WORD_BITS-1:0]     word;
    logic [BIT_W-1:0]         zero_bit;
    logic [CNT_W-1:0]         next_addr;
    logic [FRAME_W:0]         frame_limit;

    assign accept      = i_start && (r_state == S_IDLE);
    assign word        = r_rd_valid ? i_ram_rdata : '0;
    assign zero_bit    = lowest_zero(word);
    assign next_addr   = {1'b0, r_addr} + CNT_W'(1);
    assign frame_limit = {i_nwords, {BIT_W{1'b0}}};

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_bit       = r_bit;
        n_kernel    = r_kernel;
        n_wr        = r_wr;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_addr;
        o_ram_wdata = word;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        n_res       = '{done: 1'b0, frame: '0, status: ST_OK,
                        present: 1'b0, rw: 1'b0, user: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kernel = i_kernel_page;
                    n_wr     = i_writable;
                    if (i_cmd == CMD_ALLOC) begin
                        if (i_frame_in != '0) begin
                            n_res.done   = 1'b1;
                            n_res.frame  = i_frame_in;
                            n_res.status = ST_ALREADY_MAPPED;
                        end else if (i_nwords == '0) begin
                            n_res.done   = 1'b1;
                            n_res.status = ST_FULL;
                        end else begin
                            o_ram_re    = 1'b1;
                            o_ram_raddr = '0;
                            n_addr      = '0;
                            n_state     = S_SCAN;
                        end
                    end else begin
                        if (i_frame_in == '0) begin
                            n_res.done   = 1'b1;
                            n_res.status = ST_NOTHING_TO_FREE;
                        end else if ({1'b0, i_frame_in} >= frame_limit) begin
                            n_res.done   = 1'b1;
                            n_res.status = ST_OUT_OF_RANGE;
                        end else begin
                            o_ram_re    = 1'b1;
                            o_ram_raddr = i_frame_in[FRAME_W-1:BIT_W];
                            n_addr      = i_frame_in[FRAME_W-1:BIT_W];
                            n_bit       = i_frame_in[BIT_W-1:0];
                            n_state     = S_FREE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (word != ALL_ONES) begin
                    o_ram_we      = 1'b1;
                    o_ram_wdata   = word | (WORD_BITS'(1) << zero_bit);
                    n_res.done    = 1'b1;
                    n_res.frame   = {r_addr, zero_bit};
                    n_res.status  = ST_OK;
                    n_res.present = 1'b1;
                    n_res.rw      = r_wr;
                    n_res.user    = ~r_kernel;
                    n_state       = S_IDLE;
                end else if (next_addr == i_nwords) begin
                    n_res.done   = 1'b1;
                    n_res.status = ST_FULL;
                    n_state      = S_IDLE;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = next_addr[ADDR_W-1:0];
                    n_addr      = next_addr[ADDR_W-1:0];
                end
            end
            S_FREE: begin
                o_ram_we     = 1'b1;
                o_ram_wdata  = word & ~(WORD_BITS'(1) << r_bit);
                n_res.done   = 1'b1;
                n_res.status = ST_OK;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_res   <= '{done: 1'b0, frame: '0, status: ST_OK,
                         present: 1'b0, rw: 1'b0, user: 1'b0};
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            if (o_ram_we) begin
                r_valid[o_ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_bit    <= n_bit;
        r_kernel <= n_kernel;
        r_wr     <= n_wr;
        if (o_ram_re) begin
            r_rd_valid <= r_valid[o_ram_raddr];
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

### rtl/core/frame_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// First-fit physical frame allocator over a bitmap of 32-bit words.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// request   in         start high, busy low     i_cmd, i_frame_in, i_kernel_page,
//                                               i_writable
// result    out        o_done, one cycle        o_frame_out, o_status, o_present_bit,
//                                               o_rw_bit, o_user_bit
// config    in         i_cfg_we                 i_cfg_wdata (word_count)
//
// An allocation scans the bitmap words in order from word 0 until it finds a clear bit
// or passes the last word in use, at most 128; the single read port takes them in turn.
// A free in range reads and then writes back its word; others end on acceptance.
// The result appears in the cycle after the last one of its transaction.
// Reset clears per-word valid flags, so the bitmap reads as all free at once.
// The receiver cannot stall; busy holds off requests during a scan or a free write-back.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cmd,
    input  logic [fba_pkg::FRAME_W-1:0]     i_frame_in,
    input  logic                            i_kernel_page,
    input  logic                            i_writable,
    input  logic                            i_cfg_we,
    input  logic [fba_pkg::CNT_W-1:0]       i_cfg_wdata,
    output logic                            o_done,
    output logic [fba_pkg::FRAME_W-1:0]     o_frame_out,
    output fba_pkg::t_status                o_status,
    output logic                            o_present_bit,
    output logic                            o_rw_bit,
    output logic                            o_user_bit
);
    import fba_pkg::*;

    logic [CNT_W-1:0]      r_word_count;
    logic [CNT_W-1:0]      nwords;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;
    t_result               res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= CNT_W'(MAX_WORDS);
        end else if (i_cfg_we) begin
            r_word_count <= i_cfg_wdata;
        end
    end

    assign nwords = (r_word_count > CNT_W'(BITMAP_WORDS)) ? CNT_W'(BITMAP_WORDS)
                                                          : r_word_count;

    fba_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_cmd         (i_cmd),
        .i_frame_in    (i_frame_in),
        .i_kernel_page (i_kernel_page),
        .i_writable    (i_writable),
        .i_nwords      (nwords),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_busy        (busy),
        .o_res         (res)
    );

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BITMAP_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_done        = res.done;
    assign o_frame_out   = res.frame;
    assign o_status      = res.status;
    assign o_present_bit = res.present;
    assign o_rw_bit      = res.rw;
    assign o_user_bit    = res.user;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("Result strobe while a transaction is still running.");

    a_mapped_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_ALLOC && i_frame_in != '0)
        |=> (o_done && o_status == ST_ALREADY_MAPPED && o_frame_out == $past(i_frame_in)))
        else $error("Mapped page did not return its frame in the next cycle.");

    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_present_bit)
        |-> ({1'b0, o_frame_out} < {nwords, {BIT_W{1'b0}}}))
        else $error("Allocated frame lies beyond the words in use.");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (!o_present_bit && !o_rw_bit && !o_user_bit))
        else $error("Failed transaction carries page flags.");
`endif

endmodule

### test/frame_bitmap_allocator_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator checker
// Watches the request, result and configuration channels of the allocator.
// It keeps its own bitmap and word count and predicts each reply on
// acceptance. It also compares every reply field by field with the oldest
// prediction, and counts failures for the testbench top.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic                            i_cmd,
    input  logic [fba_pkg::FRAME_W-1:0]     i_frame_in,
    input  logic                            i_kernel_page,
    input  logic                            i_writable,
    input  logic                            i_cfg_we,
    input  logic [fba_pkg::CNT_W-1:0]       i_cfg_wdata,
    input  logic                            i_done,
    input  logic [fba_pkg::FRAME_W-1:0]     i_frame_out,
    input  fba_pkg::t_status                i_status,
    input  logic                            i_present_bit,
    input  logic                            i_rw_bit,
    input  logic                            i_user_bit,
    output int                              o_fail_count,
    output int                              o_pending_count
);
    import fba_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        t_status            status;
        logic               present;
        logic               rw;
        logic               user;
    } t_reply;

    logic [WORD_BITS-1:0] frame_map [BITMAP_WORDS];
    logic [CNT_W-1:0]     word_count;
    t_reply               reply_q[$];
    int                   fail_total;

    function automatic int active_words();
        int n;
        n = int'(word_count);
        if (n > BITMAP_WORDS) begin
            n = BITMAP_WORDS;
        end
        if (n > MAX_WORDS) begin
            n = MAX_WORDS;
        end
        return n;
    endfunction

    // Applies one request to the local bitmap and returns the reply it causes.
    function automatic t_reply apply_request(input logic cmd, input logic [FRAME_W-1:0] frame,
                                             input logic kernel, input logic wr);
        t_reply r;
        int     n;
        int     b;
        n = active_words();
        r = '{frame: '0, status: ST_OK, present: 1'b0, rw: 1'b0, user: 1'b0};
        if (cmd == CMD_ALLOC) begin
            if (frame != '0) begin
                r.frame  = frame;
                r.status = ST_ALREADY_MAPPED;
                return r;
            end
            for (int w = 0; w < n; w++) begin
                if (frame_map[w] != ALL_ONES) begin
                    b = 0;
                    while (b < WORD_BITS - 1 && frame_map[w][b]) begin
                        b++;
                    end
                    frame_map[w][b] = 1'b1;
                    r.frame   = FRAME_W'(w * WORD_BITS + b);
                    r.present = 1'b1;
                    r.rw      = wr;
                    r.user    = ~kernel;
                    return r;
                end
            end
            r.status = ST_FULL;
            return r;
        end
        if (frame == '0) begin
            r.status = ST_NOTHING_TO_FREE;
        end else if (int'(frame) >= n * WORD_BITS) begin
            r.status = ST_OUT_OF_RANGE;
        end else begin
            frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply seen;
        t_reply want;
        if (!i_rst_n) begin
            for (int w = 0; w < BITMAP_WORDS; w++) begin
                frame_map[w] = '0;
            end
            word_count = CNT_W'(MAX_WORDS);
            reply_q.delete();
        end else begin
            if (i_done) begin
                seen = '{frame: i_frame_out, status: i_status, present: i_present_bit,
                         rw: i_rw_bit, user: i_user_bit};
                if (reply_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("unexpected reply: frame %0d status %0d p %0b rw %0b u %0b",
                                 seen.frame, seen.status, seen.present, seen.rw, seen.user);
                    end
                end else begin
                    want = reply_q.pop_front();
                    if (seen.frame !== want.frame || seen.status !== want.status ||
                        seen.present !== want.present || seen.rw !== want.rw ||
                        seen.user !== want.user) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("mismatch, expected/actual: frame %0d/%0d status %0d/%0d",
                                     want.frame, seen.frame, want.status, seen.status);
                            $display("  p %0b/%0b rw %0b/%0b u %0b/%0b",
                                     want.present, seen.present, want.rw, seen.rw,
                                     want.user, seen.user);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                reply_q.push_back(apply_request(i_cmd, i_frame_in, i_kernel_page, i_writable));
            end
            if (i_cfg_we) begin
                word_count = i_cfg_wdata;
            end
        end
        o_fail_count    <= fail_total;
        o_pending_count <= reply_q.size();
    end

endmodule

### test/frame_bitmap_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator testbench
// Drives directed and random allocate and free transactions through several
// word counts, with random sender gaps, and gives the verdict from the failure and
// pending counts of the checker. A watchdog ends runs that stop making progress.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit_tb;
    import fba_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 150;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic                 i_cmd         = CMD_ALLOC;
    logic [FRAME_W-1:0]   i_frame_in    = '0;
    logic                 i_kernel_page = 1'b0;
    logic                 i_writable    = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wdata   = '0;
    logic                 o_done;
    logic [FRAME_W-1:0]   o_frame_out;
    t_status              o_status;
    logic                 o_present_bit;
    logic                 o_rw_bit;
    logic                 o_user_bit;

    int fail_count;
    int pending_count;
    int stall_cycles = 0;
    int gap_pct      = 37;
    int live_words   = MAX_WORDS;

    always #1 i_clk = ~i_clk;

    frame_bitmap_allocator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_frame_in    (i_frame_in),
        .i_kernel_page (i_kernel_page),
        .i_writable    (i_writable),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_frame_out   (o_frame_out),
        .o_status      (o_status),
        .o_present_bit (o_present_bit),
        .o_rw_bit      (o_rw_bit),
        .o_user_bit    (o_user_bit)
    );

    frame_bitmap_allocator_unit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (i_cmd),
        .i_frame_in      (i_frame_in),
        .i_kernel_page   (i_kernel_page),
        .i_writable      (i_writable),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_done          (o_done),
        .i_frame_out     (o_frame_out),
        .i_status        (o_status),
        .i_present_bit   (o_present_bit),
        .i_rw_bit        (o_rw_bit),
        .i_user_bit      (o_user_bit),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("frame_bitmap_allocator_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(input logic cmd, input logic [FRAME_W-1:0] frame,
                                input logic kernel, input logic wr);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_frame_in    <= frame;
        i_kernel_page <= kernel;
        i_writable    <= wr;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic set_word_count(input logic [CNT_W-1:0] count);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0 || busy) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        live_words = (int'(count) > MAX_WORDS) ? MAX_WORDS : int'(count);
    endtask

    task automatic send_random_request();
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        span = live_words * WORD_BITS;
        if (pick < 50) begin
            send_request(CMD_ALLOC, '0, 1'($urandom), 1'($urandom));
        end else if (pick < 78 && span > 1) begin
            send_request(CMD_FREE, FRAME_W'($urandom_range(1, span - 1)),
                         1'($urandom), 1'($urandom));
        end else if (pick < 86) begin
            send_request(CMD_ALLOC, FRAME_W'($urandom_range(1, 4095)),
                         1'($urandom), 1'($urandom));
        end else if (pick < 95) begin
            send_request(CMD_FREE, FRAME_W'($urandom_range(1, 4095)),
                         1'($urandom), 1'($urandom));
        end else begin
            send_request(CMD_FREE, '0, 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int phase_counts [12];
        phase_counts = '{1, 2, 3, 255, 1, 4, 0, 2, 128, 0, 200, 3};
        phase_counts[9] = $urandom_range(1, 6);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_ALLOC, '0, 1'b0, 1'b1);
        send_request(CMD_ALLOC, '0, 1'b1, 1'b0);
        send_request(CMD_ALLOC, 12'hFFF, 1'b1, 1'b1);
        send_request(CMD_ALLOC, 12'h001, 1'b0, 1'b0);
        send_request(CMD_FREE, '0, 1'b0, 1'b0);
        send_request(CMD_FREE, 12'hFFF, 1'b1, 1'b1);
        send_request(CMD_FREE, 12'h001, 1'b0, 1'b0);
        send_request(CMD_FREE, 12'h005, 1'b0, 1'b0);
        send_request(CMD_ALLOC, '0, 1'b1, 1'b1);
        send_request(CMD_ALLOC, '0, 1'b0, 1'b0);

        set_word_count(8'd0);
        send_request(CMD_ALLOC, '0, 1'b0, 1'b1);
        send_request(CMD_FREE, 12'hFFF, 1'b0, 1'b0);
        send_request(CMD_FREE, 12'h001, 1'b0, 1'b0);
        send_request(CMD_FREE, '0, 1'b0, 1'b0);
        send_request(CMD_ALLOC, 12'h007, 1'b1, 1'b0);

        set_word_count(8'd255);
        send_request(CMD_FREE, 12'hFFF, 1'b0, 1'b0);
        send_request(CMD_FREE, 12'hFE0, 1'b0, 1'b0);
        send_request(CMD_ALLOC, '0, 1'b1, 1'b1);
        send_request(CMD_FREE, 12'h000, 1'b1, 1'b1);

        for (int p = 0; p < 12; p++) begin
            gap_pct = (p < 4) ? 37 : (p < 8) ? 87 : 0;
            set_word_count(CNT_W'(phase_counts[p]));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_random_request();
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("frame_bitmap_allocator_unit test passed");
        end else begin
            $display("frame_bitmap_allocator_unit test failed");
        end
        $finish;
    end

endmodule

### frame_bitmap_allocator_unit.f
rtl/core/fba_pkg.sv
rtl/core/fba_ram.sv
rtl/core/fba_ctrl.sv
rtl/core/frame_bitmap_allocator_unit.sv
test/frame_bitmap_allocator_unit_checker.sv
test/frame_bitmap_allocator_unit_tb.sv
